>>> sv/sha1s_pkg.sv
// ----------------------------------------------------------------------------
// sha1s_pkg: shared types and constants of the SHA-1 stream hasher
// Holds the word structs of both channels, the controller state and command
// types, and the SHA-1 initial chaining value and round constants.
// ----------------------------------------------------------------------------
package sha1s_pkg;

  // Input word: one message byte plus framing flags.
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  // Output word: one digest word with its position.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Source of the byte shifted into the block register.
  typedef enum logic [1:0] {
    SEL_MSG,
    SEL_PAD,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_ADD,
    ST_PAD,
    ST_LOAD
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      shift;
    byte_sel_e sel;
    logic      start;
    logic      round;
    logic      add;
    logic      load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic ge56;
    logic round_last;
    logic out_busy;
  } status_t;

  localparam logic [159:0] SHA1_IV = {
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [6:0] NUM_ROUNDS_M1 = 7'd79;

endpackage

>>> sv/sha1s_ctrl.sv
// ----------------------------------------------------------------------------
// sha1s_ctrl: controller of the SHA-1 stream hasher
// Sequences byte intake, padding, the 80 compression rounds, the chaining
// update and the hand-off of the digest to the output register.
// ----------------------------------------------------------------------------
module sha1s_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sha1s_pkg::in_item_t in_data_i,
  output logic               in_stall_o,
  input  sha1s_pkg::status_t sts_i,
  output sha1s_pkg::cmd_t    cmd_o
);

  sha1s_pkg::ctrl_state_e state_q, state_d;
  logic pad_q, pad_d;       // padding of the current message is under way
  logic sent80_q, sent80_d; // the 0x80 marker byte has been placed
  logic extra_q, extra_d;   // the marker needs a block of its own before the length
  logic lenin_q, lenin_d;   // length bytes are in the block: next compression is final
  logic accept;

  assign accept = (state_q == sha1s_pkg::ST_IDLE) && !sts_i.full && in_valid_i;
  assign in_stall_o = !((state_q == sha1s_pkg::ST_IDLE) && !sts_i.full);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha1s_pkg::ST_IDLE;
      pad_q    <= 1'b0;
      sent80_q <= 1'b0;
      extra_q  <= 1'b0;
      lenin_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      pad_q    <= pad_d;
      sent80_q <= sent80_d;
      extra_q  <= extra_d;
      lenin_q  <= lenin_d;
    end
  end

  // Next state and padding flags.
  always_comb begin
    state_d  = state_q;
    pad_d    = pad_q;
    sent80_d = sent80_q;
    extra_d  = extra_q;
    lenin_d  = lenin_q;
    unique case (state_q)
      sha1s_pkg::ST_IDLE: begin
        if (sts_i.full) begin
          state_d = sha1s_pkg::ST_RUN;
        end else if (accept && in_data_i.end_of_message) begin
          state_d = sha1s_pkg::ST_PAD;
          pad_d   = 1'b1;
        end
      end
      sha1s_pkg::ST_RUN: begin
        if (sts_i.round_last) state_d = sha1s_pkg::ST_ADD;
      end
      sha1s_pkg::ST_ADD: begin
        if (lenin_q) begin
          state_d = sha1s_pkg::ST_LOAD;
        end else if (pad_q) begin
          state_d = sha1s_pkg::ST_PAD;
        end else begin
          state_d = sha1s_pkg::ST_IDLE;
        end
      end
      sha1s_pkg::ST_PAD: begin
        if (sts_i.full) begin
          state_d = sha1s_pkg::ST_RUN;
          extra_d = 1'b0;
        end else if (!sent80_q) begin
          sent80_d = 1'b1;
          extra_d  = sts_i.ge56;
        end else if (!extra_q && sts_i.ge56) begin
          lenin_d = 1'b1;
        end
      end
      sha1s_pkg::ST_LOAD: begin
        if (!sts_i.out_busy) begin
          state_d  = sha1s_pkg::ST_IDLE;
          pad_d    = 1'b0;
          sent80_d = 1'b0;
          extra_d  = 1'b0;
          lenin_d  = 1'b0;
        end
      end
      default: state_d = sha1s_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o = '0;
    cmd_o.sel = sha1s_pkg::SEL_MSG;
    unique case (state_q)
      sha1s_pkg::ST_IDLE: begin
        cmd_o.start = sts_i.full;
        cmd_o.shift = accept && in_data_i.byte_present;
      end
      sha1s_pkg::ST_RUN: cmd_o.round = 1'b1;
      sha1s_pkg::ST_ADD: cmd_o.add = 1'b1;
      sha1s_pkg::ST_PAD: begin
        if (sts_i.full) begin
          cmd_o.start = 1'b1;
        end else begin
          cmd_o.shift = 1'b1;
          if (!sent80_q) begin
            cmd_o.sel = sha1s_pkg::SEL_PAD;
          end else if (extra_q || !sts_i.ge56) begin
            cmd_o.sel = sha1s_pkg::SEL_ZERO;
          end else begin
            cmd_o.sel = sha1s_pkg::SEL_LEN;
          end
        end
      end
      sha1s_pkg::ST_LOAD: cmd_o.load_out = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> sv/sha1s_dp.sv
// ----------------------------------------------------------------------------
// sha1s_dp: datapath of the SHA-1 stream hasher
// Holds the 64-byte block shift line, which doubles as the 16-word message
// schedule window, the working and chaining words, the bit count, the
// round unit and the digest output register.
// ----------------------------------------------------------------------------
module sha1s_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           message_byte_i,
  input  sha1s_pkg::cmd_t      cmd_i,
  output sha1s_pkg::status_t   sts_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sha1s_pkg::out_item_t out_data_o
);

  logic [511:0] blk_q, blk_d;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  a_d, b_d, c_d, d_d, e_d;
  logic [159:0] h_q, h_d;
  logic [63:0]  bits_q, bits_d;
  logic [6:0]   fill_q, fill_d;
  logic [6:0]   round_q, round_d;
  logic [159:0] dig_q, dig_d;
  logic [2:0]   idx_q, idx_d;
  logic         ovalid_q, ovalid_d;

  logic [7:0]   in_byte;
  logic [63:0]  len_shift;
  logic [31:0]  w_new, w_tmp, fn, kc, sum;
  logic         out_take;

  // Length byte: fill 56 takes the most significant byte.
  assign len_shift = bits_q >> {~fill_q[2:0], 3'b000};

  always_comb begin
    unique case (cmd_i.sel)
      sha1s_pkg::SEL_MSG:  in_byte = message_byte_i;
      sha1s_pkg::SEL_PAD:  in_byte = sha1s_pkg::PAD_BYTE;
      sha1s_pkg::SEL_ZERO: in_byte = 8'h00;
      sha1s_pkg::SEL_LEN:  in_byte = len_shift[7:0];
      default:             in_byte = 8'h00;
    endcase
  end

  // Schedule expansion: the window's top word is W[t].
  assign w_tmp = blk_q[95:64] ^ blk_q[255:224] ^ blk_q[447:416] ^ blk_q[511:480];
  assign w_new = {w_tmp[30:0], w_tmp[31]};

  // Round function and constant by round range.
  always_comb begin
    if (round_q < 7'd20) begin
      fn = (b_q & c_q) | (~b_q & d_q);
      kc = sha1s_pkg::K0;
    end else if (round_q < 7'd40) begin
      fn = b_q ^ c_q ^ d_q;
      kc = sha1s_pkg::K1;
    end else if (round_q < 7'd60) begin
      fn = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      kc = sha1s_pkg::K2;
    end else begin
      fn = b_q ^ c_q ^ d_q;
      kc = sha1s_pkg::K3;
    end
  end

  assign sum = {a_q[26:0], a_q[31:27]} + fn + e_q + kc + blk_q[511:480];

  assign out_take = ovalid_q && !out_stall_i;

  // Next values of the datapath registers.
  always_comb begin
    blk_d    = blk_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    d_d      = d_q;
    e_d      = e_q;
    h_d      = h_q;
    bits_d   = bits_q;
    fill_d   = fill_q;
    round_d  = round_q;
    dig_d    = dig_q;
    idx_d    = idx_q;
    ovalid_d = ovalid_q;

    if (cmd_i.shift) begin
      blk_d  = {blk_q[503:0], in_byte};
      fill_d = fill_q + 7'd1;
      if (cmd_i.sel == sha1s_pkg::SEL_MSG) bits_d = bits_q + 64'd8;
    end

    if (cmd_i.start) begin
      a_d     = h_q[159:128];
      b_d     = h_q[127:96];
      c_d     = h_q[95:64];
      d_d     = h_q[63:32];
      e_d     = h_q[31:0];
      fill_d  = 7'd0;
      round_d = 7'd0;
    end

    if (cmd_i.round) begin
      a_d     = sum;
      b_d     = a_q;
      c_d     = {b_q[1:0], b_q[31:2]};
      d_d     = c_q;
      e_d     = d_q;
      blk_d   = {blk_q[479:0], w_new};
      round_d = round_q + 7'd1;
    end

    if (cmd_i.add) begin
      h_d = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
             h_q[63:32] + d_q, h_q[31:0] + e_q};
    end

    // Digest words drain from the top of the output register.
    if (out_take) begin
      if (idx_q == 3'd4) begin
        ovalid_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
        dig_d = {dig_q[127:0], 32'h0};
      end
    end

    if (cmd_i.load_out) begin
      dig_d    = h_q;
      idx_d    = 3'd0;
      ovalid_d = 1'b1;
      h_d      = sha1s_pkg::SHA1_IV;
      bits_d   = 64'd0;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q      <= sha1s_pkg::SHA1_IV;
      bits_q   <= 64'd0;
      fill_q   <= 7'd0;
      round_q  <= 7'd0;
      idx_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      h_q      <= h_d;
      bits_q   <= bits_d;
      fill_q   <= fill_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
    dig_q <= dig_d;
  end

  assign sts_o.full       = fill_q[6];
  assign sts_o.ge56       = !fill_q[6] && (fill_q[5:3] == 3'b111);
  assign sts_o.round_last = (round_q == sha1s_pkg::NUM_ROUNDS_M1);
  assign sts_o.out_busy   = ovalid_q;

  assign out_valid_o            = ovalid_q;
  assign out_data_o.digest_word = dig_q[159:128];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == 3'd4);

endmodule

>>> sv/sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha1_stream_hasher: SHA-1 digest over a byte stream
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Message bytes arrive one per word and are taken at one per cycle until
// 64 bytes are held; the block is then compressed by a single round unit
// (load, 80 rounds, chaining add) while input stalls. An end-of-message
// word starts padding, which shifts one pad byte per cycle and adds one or
// two compressions, the second when the length needs a block of its own.
// The digest then leaves as five 32-bit words, most significant first, from
// an output register; a new message may be taken in while these words drain.
module sha1_stream_hasher (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sha1s_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sha1s_pkg::out_item_t out_data_o
);

  sha1s_pkg::cmd_t    cmd;
  sha1s_pkg::status_t sts;

  sha1s_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sha1s_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .message_byte_i (in_data_i.message_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule

>>> sim/sha1_digest_checker.sv
// ----------------------------------------------------------------------------
// sha1_digest_checker: scoreboard for the SHA-1 stream hasher
// Watches both channels of the hasher and keeps its own SHA-1 message state.
// Every word taken in updates that state, and every message end queues the
// five digest words due. Each digest word that leaves the block is compared
// field by field with the oldest queued word.
// ----------------------------------------------------------------------------
module sha1_digest_checker
  import sha1s_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_item_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_item_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned digests_o,
  output int unsigned words_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLOCK_BYTES  = 64;
  localparam int unsigned LENGTH_POS   = 56;
  localparam int unsigned DIGEST_WORDS = 5;

  // Predicted message state.
  logic [31:0] chain_q [DIGEST_WORDS];
  logic [7:0]  block_q [BLOCK_BYTES];
  int unsigned fill_q;
  logic [63:0] bit_len_q;

  // Digest words predicted but not yet seen on the output.
  out_item_t   digest_words_due [$];

  int unsigned fails   = 0;
  int unsigned digests = 0;
  int unsigned checked = 0;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Back to the initial chaining value with no bytes held.
  function automatic void restart_message();
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      chain_q[i] = SHA1_IV[159 - 32 * i -: 32];
    end
    fill_q    = 0;
    bit_len_q = '0;
  endfunction

  // One 80-round compression of the held block into the chaining words.
  function automatic void sha1_compress();
    logic [31:0] sched [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_q[4 * i], block_q[4 * i + 1], block_q[4 * i + 2], block_q[4 * i + 3]};
    end
    for (int i = 16; i < 80; i++) begin
      sched[i] = rotl(sched[i - 3] ^ sched[i - 8] ^ sched[i - 14] ^ sched[i - 16], 1);
    end
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    e = chain_q[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      t = rotl(a, 5) + f + e + k + sched[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
    chain_q[4] += e;
  endfunction

  // Add one message byte; a full block is compressed at once.
  function automatic void absorb_byte(input logic [7:0] value);
    block_q[fill_q] = value;
    fill_q++;
    bit_len_q += 64'd8;
    if (fill_q == BLOCK_BYTES) begin
      sha1_compress();
      fill_q = 0;
    end
  endfunction

  // Pad, append the bit length, queue the digest and start over.
  function automatic void close_message();
    out_item_t word;
    block_q[fill_q] = PAD_BYTE;
    fill_q++;
    // No room left for the length: finish this block and pad another one.
    if (fill_q > LENGTH_POS) begin
      while (fill_q < BLOCK_BYTES) begin
        block_q[fill_q] = '0;
        fill_q++;
      end
      sha1_compress();
      fill_q = 0;
    end
    while (fill_q < LENGTH_POS) begin
      block_q[fill_q] = '0;
      fill_q++;
    end
    for (int i = 0; i < 8; i++) begin
      block_q[LENGTH_POS + i] = bit_len_q[63 - 8 * i -: 8];
    end
    sha1_compress();
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      word.digest_word = chain_q[i];
      word.word_index  = 3'(i);
      word.last_word   = (i == DIGEST_WORDS - 1);
      digest_words_due.push_back(word);
    end
    digests++;
    restart_message();
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch on digest word %0d: expected %h, actual %h",
               $time, field, checked, want, got);
    end
  endfunction

  // Compare the word leaving the block first, then take in the word entering it.
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    out_item_t due;
    if (!rst_ni) begin
      restart_message();
      digest_words_due.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (digest_words_due.size() == 0) begin
          fails++;
          $display("%0t: digest word with nothing expected: expected none, actual %h/%0d/%0b",
                   $time, out_data_i.digest_word, out_data_i.word_index,
                   out_data_i.last_word);
        end else begin
          due = digest_words_due.pop_front();
          check_field("digest_word", due.digest_word, out_data_i.digest_word);
          check_field("word_index", 32'(due.word_index), 32'(out_data_i.word_index));
          check_field("last_word", 32'(due.last_word), 32'(out_data_i.last_word));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.byte_present) begin
          absorb_byte(in_data_i.message_byte);
        end
        if (in_data_i.end_of_message) begin
          close_message();
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= digest_words_due.size();
    digests_o       <= digests;
    words_checked_o <= checked;
  end

endmodule

>>> sim/tb_sha1_stream_hasher.sv
// ----------------------------------------------------------------------------
// tb_sha1_stream_hasher: testbench of the SHA-1 stream hasher
// Feeds short directed messages and then random messages of many lengths,
// including those at the padding boundaries, with random gaps on the input
// and random stalls on the output, one of them long enough to back the block
// up. A separate checker predicts and compares every digest word.
// ----------------------------------------------------------------------------
module tb_sha1_stream_hasher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET    = 360;
  localparam int unsigned HOLD_CYCLES    = 2500;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES   = 400;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  sha1s_pkg::in_item_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  sha1s_pkg::out_item_t out_data_o;

  int unsigned fail_count;
  int unsigned pending_words;
  int unsigned digests_seen;
  int unsigned words_checked;

  int unsigned item_count    = 0;
  int unsigned messages_sent = 0;
  int unsigned longest       = 0;
  int unsigned idle_cycles   = 0;
  bit          directed_done = 1'b0;

  sha1_stream_hasher u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  sha1_digest_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words),
    .digests_o       (digests_seen),
    .words_checked_o (words_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gap before a word: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Message length: mostly short, many at the padding boundaries, a few long.
  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 12);
    else if (r < 75) begin
      case ($urandom_range(0, 4))
        0:       return 55;
        1:       return 56;
        2:       return 63;
        3:       return 64;
        default: return 119;
      endcase
    end
    else if (r < 92) return $urandom_range(13, 54);
    else return $urandom_range(65, 130);
  endfunction

  // Offer one word and hold it until the block accepts it.
  task automatic send_word(input logic [7:0] value, input logic present, input logic last,
                           input bit steady);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{message_byte: value, byte_present: present, end_of_message: last};
    do @(posedge clk_i); while (in_stall_o);
    item_count++;
    @(negedge clk_i);
  endtask

  // One message with random bytes, a few no-op words mixed in, and the end
  // marked either on the last byte or by an empty word.
  task automatic send_message(input int unsigned len);
    bit steady;
    bit separate_end;
    steady       = ($urandom_range(0, 3) == 0);
    separate_end = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) send_word(8'($urandom), 1'b0, 1'b0, steady);
      send_word(8'($urandom), 1'b1, !separate_end && (i == len - 1), steady);
    end
    if (separate_end) send_word(8'($urandom), 1'b0, 1'b1, steady);
    messages_sent++;
    if (len > longest) longest = len;
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    int unsigned len;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty message, with an ignored byte of all ones.
    send_word(8'hFF, 1'b0, 1'b1, 1'b0);
    // "abc", ended on its last byte.
    send_word(8'h61, 1'b1, 1'b0, 1'b0);
    send_word(8'h62, 1'b1, 1'b0, 1'b0);
    send_word(8'h63, 1'b1, 1'b1, 1'b0);
    // Extreme bytes with no-op words between them and a separate end word.
    send_word(8'h00, 1'b1, 1'b0, 1'b0);
    send_word(8'hAA, 1'b0, 1'b0, 1'b0);
    send_word(8'hFF, 1'b1, 1'b0, 1'b0);
    send_word(8'h55, 1'b0, 1'b1, 1'b0);
    // A byte equal to the pad byte.
    send_word(8'h80, 1'b1, 1'b1, 1'b0);
    // No-op words, then an empty message.
    send_word(8'h12, 1'b0, 1'b0, 1'b0);
    send_word(8'hED, 1'b0, 1'b0, 1'b0);
    send_word(8'h00, 1'b0, 1'b1, 1'b0);
    // Back-to-back short messages with no gaps.
    send_word(8'h01, 1'b1, 1'b0, 1'b1);
    send_word(8'hFE, 1'b1, 1'b1, 1'b1);
    send_word(8'h7F, 1'b1, 1'b1, 1'b1);
    messages_sent = 7;
    longest       = 3;
    directed_done = 1'b1;

    // Random messages, the last one cut short to land near the word budget.
    while (item_count < ITEM_TARGET) begin
      len = pick_length();
      if (len > ITEM_TARGET - item_count) len = ITEM_TARGET - item_count;
      send_message(len);
    end
    in_valid_i <= 1'b0;

    wait (pending_words == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Hashed %0d messages in %0d words, longest %0d bytes.",
             messages_sent, item_count, longest);
    $display("Checked %0d digest words of %0d digests under random gaps, stalls",
             words_checked, digests_seen);
    $display("and a %0d-cycle hold-off.", HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random stall runs, with one long hold-off once the directed
  // part is over so that the block backs up and stalls its input.
  initial begin : receiver
    int unsigned stall_len;
    int unsigned free_len;
    int unsigned r;
    bit          hold_done;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (!hold_done && directed_done) begin
        hold_done = 1'b1;
        stall_len = HOLD_CYCLES;
      end else if (r < 70) stall_len = $urandom_range(1, 3);
      else if (r < 95) stall_len = $urandom_range(4, 15);
      else stall_len = $urandom_range(30, 120);
      r = $urandom_range(0, 99);
      if (r < 60) free_len = $urandom_range(1, 4);
      else if (r < 90) free_len = $urandom_range(5, 20);
      else free_len = $urandom_range(50, 200);
      out_stall_i <= 1'b1;
      repeat (stall_len) @(negedge clk_i);
      out_stall_i <= 1'b0;
      repeat (free_len) @(negedge clk_i);
    end
  end

  // Watchdog: cycles in a row with no word accepted on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

endmodule
